### src/lbs_pkg.sv
// Shared types, widths and helpers for the linear blend skinning unit.
// No dependencies; imported by every file except the two interfaces.
`timescale 1ns / 1ps

package lbs_pkg;

  localparam int MAX_JOINTS    = 128;
  localparam int INFLUENCES    = 4;
  localparam int ROW_WORDS     = 12;
  localparam int PALETTE_WORDS = MAX_JOINTS * ROW_WORDS;
  localparam int JOINT_W       = 7;
  localparam int SLOT_W        = 11;
  localparam int WORD_W        = 4;
  localparam int BEAT_W        = 2;
  localparam int CFG_W         = 8;

  // reciprocal of twelve, exact for every slot below PALETTE_WORDS
  localparam int RECIP12       = 2731;
  localparam int RECIP_SH      = 15;

  // datapath widths
  localparam int PROD_W = 64;
  localparam int SUM_W  = 66;
  localparam int T_W    = 52;
  localparam int TH_W   = T_W - 15;
  localparam int TL_W   = 15;
  localparam int PH_W   = 17 + TH_W;
  localparam int PL_W   = 16 + TL_W;
  localparam int ACH_W  = PH_W + 2;
  localparam int ACL_W  = PL_W + 2;
  localparam int V_W    = ACH_W + 1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_SKIN  = 1'b1
  } op_t;

  typedef logic [ROW_WORDS-1:0][31:0] mrow_t;

  // one palette word write
  typedef struct packed {
    logic               en;
    logic [JOINT_W-1:0] row;
    logic [WORD_W-1:0]  word;
    logic [31:0]        data;
  } pal_wr_t;

  // one influence beat travelling down the datapath
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic               fault;
    logic [15:0]        weight;
    logic [15:0]        tag;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } beat_t;

  // split a palette slot into joint row and word within the row
  function automatic logic [JOINT_W+WORD_W-1:0] split_slot(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W+12-1:0] prod;
    logic [JOINT_W-1:0]   row;
    logic [SLOT_W-1:0]    base;
    logic [SLOT_W-1:0]    rem;
    prod = (SLOT_W + 12)'(slot) * (SLOT_W + 12)'(RECIP12);
    row  = JOINT_W'(prod >> RECIP_SH);
    base = SLOT_W'(row) * SLOT_W'(ROW_WORDS);
    rem  = slot - base;
    return {row, rem[WORD_W-1:0]};
  endfunction

endpackage

### src/lbs_in_if.sv
// Input channel of the skinning unit: palette writes and skin requests.
// Depends on nothing.
`timescale 1ns / 1ps

interface lbs_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [10:0]        matrix_slot;
  logic signed [31:0] matrix_value;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [27:0]        joints_packed;
  logic [15:0]        weight_a;
  logic [15:0]        weight_b;
  logic [15:0]        weight_c;
  logic [15:0]        weight_d;
  logic [15:0]        sample_index;

  modport source (output valid, operation, matrix_slot, matrix_value, pos_x, pos_y, pos_z,
                  joints_packed, weight_a, weight_b, weight_c, weight_d, sample_index,
                  input ready);
  modport sink (input valid, operation, matrix_slot, matrix_value, pos_x, pos_y, pos_z,
                joints_packed, weight_a, weight_b, weight_c, weight_d, sample_index,
                output ready);
endinterface

### src/lbs_out_if.sv
// Output channel of the skinning unit: one skinned vertex per item.
// Depends on nothing.
`timescale 1ns / 1ps

interface lbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] skinned_x;
  logic signed [31:0] skinned_y;
  logic signed [31:0] skinned_z;
  logic               index_fault;
  logic [15:0]        result_tag;

  modport source (output valid, skinned_x, skinned_y, skinned_z, index_fault, result_tag,
                  input ready);
  modport sink (input valid, skinned_x, skinned_y, skinned_z, index_fault, result_tag,
                output ready);
endinterface

### src/lbs_palette.sv
// Matrix palette memory: one joint matrix per row, word-granular writes.
// Depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_palette (
  input  logic                    clk,
  input  lbs_pkg::pal_wr_t        wr,
  input  logic                    rd_en,
  input  logic [lbs_pkg::JOINT_W-1:0] rd_row,
  output lbs_pkg::mrow_t          rd_data
);
  import lbs_pkg::*;

  mrow_t mem [MAX_JOINTS];

  // write one word of a row
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row][wr.word] <= wr.data;
    end
  end

  // read a whole row, hold while stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

### src/lbs_seq.sv
// Front sequencer: takes items, writes the palette, steps a skin item through its
// four influences, one palette row read per unstalled cycle. Depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_seq (
  input  logic                      clk,
  input  logic                      rst,
  lbs_in_if.sink                    in_ch,
  input  logic [lbs_pkg::CFG_W-1:0] joint_count,
  input  logic                      stall,
  output lbs_pkg::pal_wr_t          wr,
  output logic [lbs_pkg::JOINT_W-1:0] rd_row,
  output lbs_pkg::beat_t            beat
);
  import lbs_pkg::*;

  logic                                 busy;
  logic [BEAT_W-1:0]                    cnt;
  logic [INFLUENCES-1:0][JOINT_W-1:0]   held_joint;
  logic [INFLUENCES-1:0][15:0]          held_weight;
  logic [15:0]                          held_tag;
  logic                                 held_fault;
  logic signed [31:0]                   held_x, held_y, held_z;

  logic                                 take_skin;
  logic                                 take_write;
  logic                                 in_fault;
  logic [INFLUENCES-1:0][JOINT_W-1:0]   in_joint;
  logic [JOINT_W+WORD_W-1:0]            split;

  assign in_ch.ready = !busy && !stall;
  assign take_skin   = in_ch.valid && in_ch.ready && (in_ch.operation == OP_SKIN);
  assign take_write  = in_ch.valid && in_ch.ready && (in_ch.operation == OP_WRITE);

  // unpack joint indices and flag any at or above joint_count
  always_comb begin
    in_fault = 1'b0;
    for (int i = 0; i < INFLUENCES; i++) begin
      in_joint[i] = in_ch.joints_packed[i*JOINT_W +: JOINT_W];
      if ({1'b0, in_joint[i]} >= joint_count) begin
        in_fault = 1'b1;
      end
    end
  end

  // palette write port
  assign split   = split_slot(in_ch.matrix_slot);
  assign wr.en   = take_write && (in_ch.matrix_slot < SLOT_W'(PALETTE_WORDS));
  assign wr.row  = split[JOINT_W+WORD_W-1:WORD_W];
  assign wr.word = split[WORD_W-1:0];
  assign wr.data = in_ch.matrix_value;

  // issue the beat for this cycle
  always_comb begin
    beat   = '0;
    rd_row = in_joint[0];
    if (take_skin) begin
      beat.valid  = 1'b1;
      beat.first  = 1'b1;
      beat.last   = 1'b0;
      beat.fault  = in_fault;
      beat.weight = in_ch.weight_a;
      beat.tag    = in_ch.sample_index;
      beat.pos_x  = in_ch.pos_x;
      beat.pos_y  = in_ch.pos_y;
      beat.pos_z  = in_ch.pos_z;
    end else if (busy) begin
      rd_row      = held_joint[cnt];
      beat.valid  = 1'b1;
      beat.first  = 1'b0;
      beat.last   = (cnt == BEAT_W'(INFLUENCES - 1));
      beat.fault  = held_fault;
      beat.weight = held_weight[cnt];
      beat.tag    = held_tag;
      beat.pos_x  = held_x;
      beat.pos_y  = held_y;
      beat.pos_z  = held_z;
    end
  end

  // influence counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (take_skin) begin
      busy <= 1'b1;
      cnt  <= BEAT_W'(1);
    end else if (busy && !stall) begin
      cnt <= cnt + BEAT_W'(1);
      if (cnt == BEAT_W'(INFLUENCES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // hold the skin item while its influences are issued
  always_ff @(posedge clk) begin
    if (take_skin) begin
      held_joint  <= in_joint;
      held_weight <= {in_ch.weight_d, in_ch.weight_c, in_ch.weight_b, in_ch.weight_a};
      held_tag    <= in_ch.sample_index;
      held_fault  <= in_fault;
      held_x      <= in_ch.pos_x;
      held_y      <= in_ch.pos_y;
      held_z      <= in_ch.pos_z;
    end
  end

endmodule

### src/lbs_datapath.sv
// Transform and blend pipeline: per influence beat, transform the point by the
// palette row, weight it and accumulate; then round, saturate and register. Depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_datapath (
  input  logic           clk,
  input  logic           rst,
  input  lbs_pkg::beat_t beat,
  input  lbs_pkg::mrow_t mat,
  output logic           stall,
  lbs_out_if.source      out_ch
);
  import lbs_pkg::*;

  logic                               en;
  beat_t                              s1, s2, s3, s4;
  logic signed [2:0][2:0][PROD_W-1:0] prod;
  logic signed [2:0][31:0]            m3;
  logic signed [2:0][T_W-1:0]         t;
  logic signed [2:0][PH_W-1:0]        ph;
  logic [2:0][PL_W-1:0]               pl;
  logic signed [2:0][ACH_W-1:0]       acc_hi;
  logic [2:0][ACL_W-1:0]              acc_lo;
  logic                               done;
  logic                               vtx_fault;
  logic [15:0]                        vtx_tag;

  logic signed [2:0][31:0]            posv;
  logic signed [2:0][SUM_W-1:0]       rsum;
  logic signed [2:0][T_W-1:0]         t_next;
  logic signed [2:0][31:0]            sat;
  logic [ACL_W:0]                     lo_sum;
  logic signed [V_W-1:0]              v;

  assign stall = done && out_ch.valid && !out_ch.ready;
  assign en    = !stall;

  // advance beat control alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
    end else if (en) begin
      s1 <= beat;
      s2 <= s1;
      s3 <= s2;
      s4 <= s3;
    end
  end

  // row by point products
  assign posv = {s1.pos_z, s1.pos_y, s1.pos_x};
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed(mat[r*4+c]) * $signed(posv[c]);
        end
        m3[r] <= $signed(mat[r*4+3]);
      end
    end
  end

  // sum, round half up to Q16.16, add translation
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsum[r] = (SUM_W'($signed(prod[r][0])) + SUM_W'($signed(prod[r][1]))
                 + SUM_W'($signed(prod[r][2])) + SUM_W'(32768)) >>> 16;
      t_next[r] = T_W'($signed(rsum[r])) + T_W'($signed(m3[r]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t <= t_next;
    end
  end

  // weight the high and low parts of the transformed point
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        ph[r] <= $signed({1'b0, s3.weight}) * $signed(t[r][T_W-1:TL_W]);
        pl[r] <= s3.weight * t[r][TL_W-1:0];
      end
    end
  end

  // accumulate the influences of one vertex
  always_ff @(posedge clk) begin
    if (en && s4.valid) begin
      for (int r = 0; r < 3; r++) begin
        if (s4.first) begin
          acc_hi[r] <= ACH_W'($signed(ph[r]));
          acc_lo[r] <= ACL_W'(pl[r]);
        end else begin
          acc_hi[r] <= acc_hi[r] + ACH_W'($signed(ph[r]));
          acc_lo[r] <= acc_lo[r] + ACL_W'(pl[r]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else if (en) begin
      done <= s4.valid && s4.last;
    end
  end

  // hold fault and tag of the vertex whose sum is complete
  always_ff @(posedge clk) begin
    if (en && s4.valid && s4.last) begin
      vtx_fault <= s4.fault;
      vtx_tag   <= s4.tag;
    end
  end

  // round half up to Q16.16 and saturate to 32 bits
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lo_sum = (ACL_W + 1)'(acc_lo[r]) + (ACL_W + 1)'(16384);
      v      = V_W'($signed(acc_hi[r])) + V_W'(lo_sum >> 15);
      if (!v[V_W-1] && (|v[V_W-2:31])) begin
        sat[r] = 32'sh7FFF_FFFF;
      end else if (v[V_W-1] && !(&v[V_W-2:31])) begin
        sat[r] = 32'sh8000_0000;
      end else begin
        sat[r] = v[31:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (done && en) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && en) begin
      out_ch.skinned_x   <= vtx_fault ? 32'sd0 : sat[0];
      out_ch.skinned_y   <= vtx_fault ? 32'sd0 : sat[1];
      out_ch.skinned_z   <= vtx_fault ? 32'sd0 : sat[2];
      out_ch.index_fault <= vtx_fault;
      out_ch.result_tag  <= vtx_tag;
    end
  end

endmodule

### src/linear_blend_vertex_skinning_unit.sv
// Top level of the linear blend skinning unit: config register, sequencer,
// palette memory and blend pipeline. Depends on lbs_pkg, lbs_in_if, lbs_out_if.
//
//   port      dir   handshake     carries
//   vtx_in    in    valid/ready   palette word write or skin request
//   vtx_out   out   valid/ready   skinned vertex, fault flag, tag
//   cfg_*     in    write enable  joint_count
//
// A skin item reads one palette row per influence from the single row-wide
// memory port and holds the input closed until its influences are issued.
// Reset is synchronous and sets joint_count to 128; the palette is not cleared.
// A waiting result stalls the pipeline only once the next result is ready.
`timescale 1ns / 1ps

module linear_blend_vertex_skinning_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [lbs_pkg::CFG_W-1:0] cfg_wr_data,
  lbs_in_if.sink                    vtx_in,
  lbs_out_if.source                 vtx_out
);
  import lbs_pkg::*;

  logic [CFG_W-1:0]   joint_count;
  logic               stall;
  pal_wr_t            wr;
  logic [JOINT_W-1:0] rd_row;
  mrow_t              rd_data;
  beat_t              beat;

  // joint count register
  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count <= CFG_W'(MAX_JOINTS);
    end else if (cfg_wr_en) begin
      joint_count <= cfg_wr_data;
    end
  end

  lbs_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (vtx_in),
    .joint_count (joint_count),
    .stall       (stall),
    .wr          (wr),
    .rd_row      (rd_row),
    .beat        (beat)
  );

  lbs_palette u_palette (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (!stall),
    .rd_row  (rd_row),
    .rd_data (rd_data)
  );

  lbs_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .beat   (beat),
    .mat    (rd_data),
    .stall  (stall),
    .out_ch (vtx_out)
  );

  // a skin item keeps the input closed on the next cycle
  a_skin_blocks: assert property (@(posedge clk) disable iff (rst)
    (vtx_in.valid && vtx_in.ready && vtx_in.operation == OP_SKIN) |=> !vtx_in.ready)
    else $error("input reopened during a skin item");

  // a faulted result carries a zero vertex
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (vtx_out.valid && vtx_out.index_fault) |->
      (vtx_out.skinned_x == 0 && vtx_out.skinned_y == 0 && vtx_out.skinned_z == 0))
    else $error("faulted result with non-zero vertex");

  // the palette is never written while a stall holds the pipeline
  a_no_write_stalled: assert property (@(posedge clk) disable iff (rst)
    stall |-> !wr.en)
    else $error("palette write during stall");

endmodule
